>>> hdl/tdec_pkg.sv
// Shared types, constants and color helpers for the 4x4 texture block decoder.
`timescale 1ns / 1ps

package tdec_pkg;

    localparam int unsigned IDX_W     = 32;
    localparam int unsigned COLOR_W   = 15;
    localparam int unsigned CH_W      = 8;
    localparam int unsigned N_COLORS  = 4;
    localparam int unsigned CNT_W     = 4;

    // Last texel of a block: row 3, column 3
    localparam logic [CNT_W-1:0] CNT_LAST = 4'd15;

    // Palette color that stands for transparent white
    localparam logic [COLOR_W-1:0] WHITE_15 = 15'h7FFF;

    // Output format codes
    localparam logic FMT_8BIT = 1'b0;
    localparam logic FMT_6BIT = 1'b1;

    typedef enum logic [1:0] {
        MODE_TRANSP = 2'd0,
        MODE_AVG    = 2'd1,
        MODE_FOUR   = 2'd2,
        MODE_BLEND  = 2'd3
    } t_blend_mode;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] a;
    } t_texel;

    typedef t_texel [N_COLORS-1:0] t_palette;

    // One decoded block handed from the palette stage to the texel emitter
    typedef struct packed {
        logic [IDX_W-1:0] indices;
        t_palette         pal;
    } t_block;

    // Widen a 5-bit channel to 8 bits by bit replication
    function automatic logic [CH_W-1:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // Expand a 15-bit color; opaque selects alpha 255 or 0
    function automatic t_texel from15(input logic [COLOR_W-1:0] c, input logic opaque);
        t_texel t;
        t.r = widen5(c[4:0]);
        t.g = widen5(c[9:5]);
        t.b = widen5(c[14:10]);
        t.a = opaque ? 8'hFF : 8'h00;
        return t;
    endfunction

    // 5:3 blend of two 8-bit channels back to 5 bits
    function automatic logic [4:0] blend53(input logic [CH_W-1:0] x, input logic [CH_W-1:0] y);
        logic [10:0] s;
        s = {3'b000, x} * 11'd5 + {3'b000, y} * 11'd3;
        return s[10:6];
    endfunction

    // 5:3 blend of two colors, returned as an opaque expanded color
    function automatic t_texel blend_color(input t_texel p, input t_texel q);
        logic [COLOR_W-1:0] c;
        c = {blend53(p.b, q.b), blend53(p.g, q.g), blend53(p.r, q.r)};
        return from15(c, 1'b1);
    endfunction

    // Per-channel average with no carry between channels
    function automatic logic [CH_W-1:0] avg8(input logic [CH_W-1:0] x, input logic [CH_W-1:0] y);
        logic [CH_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[CH_W:1];
    endfunction

    // Narrow to 6-bit channels and 5-bit alpha
    function automatic t_texel narrow(input t_texel t);
        t_texel n;
        n.r = {2'b00, t.r[7:2]};
        n.g = {2'b00, t.g[7:2]};
        n.b = {2'b00, t.b[7:2]};
        n.a = {3'b000, t.a[7:3]};
        return n;
    endfunction

endpackage

>>> hdl/tdec_ifs.sv
// Valid/ready channel interfaces for compressed blocks and decoded texels.
`timescale 1ns / 1ps

interface tdec_blk_if;
    logic        valid;
    logic        ready;
    logic [31:0] texel_indices;
    logic [1:0]  blend_mode;
    logic [14:0] color_zero;
    logic [14:0] color_one;
    logic [14:0] color_two;
    logic [14:0] color_three;
    logic        past_slot_end;

    modport source (
        output valid, texel_indices, blend_mode, color_zero, color_one,
               color_two, color_three, past_slot_end,
        input  ready
    );
    modport sink (
        input  valid, texel_indices, blend_mode, color_zero, color_one,
               color_two, color_three, past_slot_end,
        output ready
    );
endinterface

interface tdec_tex_if;
    logic       valid;
    logic       ready;
    logic [1:0] texel_row;
    logic [1:0] texel_column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_texel;

    modport source (
        output valid, texel_row, texel_column, red, green, blue, alpha, last_texel,
        input  ready
    );
    modport sink (
        input  valid, texel_row, texel_column, red, green, blue, alpha, last_texel,
        output ready
    );
endinterface

>>> hdl/tdec_palette_stage.sv
// Builds the four-color palette of a block and holds it in a register.
`timescale 1ns / 1ps

module tdec_palette_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_output_format,
    tdec_blk_if.sink        i_blk,
    output logic            o_pal_valid,
    input  logic            i_pal_ready,
    output tdec_pkg::t_block o_pal
);

    logic              r_valid;
    tdec_pkg::t_block  r_blk;
    tdec_pkg::t_block  n_blk;
    tdec_pkg::t_palette pal;
    logic              take;

    // Take a new word when empty or when the emitter drains this one
    assign i_blk.ready = !r_valid || i_pal_ready;
    assign take        = i_blk.valid && i_blk.ready;

    // Build the palette from the incoming word
    always_comb begin
        pal[0] = tdec_pkg::from15(i_blk.color_zero, 1'b1);
        pal[1] = tdec_pkg::from15(i_blk.color_one, 1'b1);
        unique case (tdec_pkg::t_blend_mode'(i_blk.blend_mode))
            tdec_pkg::MODE_TRANSP: begin
                pal[2] = tdec_pkg::from15(i_blk.color_two, 1'b1);
                pal[3] = tdec_pkg::from15(tdec_pkg::WHITE_15, 1'b0);
            end
            tdec_pkg::MODE_AVG: begin
                pal[2].r = tdec_pkg::avg8(pal[0].r, pal[1].r);
                pal[2].g = tdec_pkg::avg8(pal[0].g, pal[1].g);
                pal[2].b = tdec_pkg::avg8(pal[0].b, pal[1].b);
                pal[2].a = 8'hFF;
                pal[3]   = tdec_pkg::from15(tdec_pkg::WHITE_15, 1'b0);
            end
            tdec_pkg::MODE_FOUR: begin
                pal[2] = tdec_pkg::from15(i_blk.color_two, 1'b1);
                pal[3] = tdec_pkg::from15(i_blk.color_three, 1'b1);
            end
            tdec_pkg::MODE_BLEND: begin
                pal[2] = tdec_pkg::blend_color(pal[0], pal[1]);
                pal[3] = tdec_pkg::blend_color(pal[1], pal[0]);
            end
            default: begin
                pal[2] = '0;
                pal[3] = '0;
            end
        endcase

        n_blk.indices = i_blk.texel_indices;
        for (int k = 0; k < tdec_pkg::N_COLORS; k++) begin
            if (i_blk.past_slot_end) begin
                n_blk.pal[k] = '0;
            end else if (i_output_format == tdec_pkg::FMT_6BIT) begin
                n_blk.pal[k] = tdec_pkg::narrow(pal[k]);
            end else begin
                n_blk.pal[k] = pal[k];
            end
        end
    end

    // Hold the palette until the emitter takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pal_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_blk <= n_blk;
        end
    end

    assign o_pal_valid = r_valid;
    assign o_pal       = r_blk;

endmodule

>>> hdl/tdec_texel_emit.sv
// Walks a decoded block and sends its sixteen texels through an output register.
`timescale 1ns / 1ps

module tdec_texel_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pal_valid,
    output logic             o_pal_ready,
    input  tdec_pkg::t_block i_pal,
    tdec_tex_if.source       o_tex
);

    logic                       r_blk_valid;
    tdec_pkg::t_block           r_blk;
    logic [tdec_pkg::CNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    tdec_pkg::t_texel           r_texel;
    logic [tdec_pkg::CNT_W-1:0] r_out_cnt;
    logic                       out_load;
    logic                       blk_load;
    logic                       blk_done;
    logic [1:0]                 sel;

    // Advance when the output register is free or drains this cycle
    assign out_load    = r_blk_valid && (!r_out_valid || o_tex.ready);
    assign blk_done    = out_load && (r_cnt == tdec_pkg::CNT_LAST);
    assign blk_load    = i_pal_valid && (!r_blk_valid || blk_done);
    assign o_pal_ready = !r_blk_valid || blk_done;

    assign sel = r_blk.indices[{r_cnt, 1'b0} +: 2];

    // Block holder and texel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (blk_load) begin
                r_blk_valid <= 1'b1;
            end else if (blk_done) begin
                r_blk_valid <= 1'b0;
            end
            if (out_load) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (blk_load) begin
            r_blk <= i_pal;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_tex.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_texel   <= r_blk.pal[sel];
            r_out_cnt <= r_cnt;
        end
    end

    assign o_tex.valid        = r_out_valid;
    assign o_tex.texel_row    = r_out_cnt[3:2];
    assign o_tex.texel_column = r_out_cnt[1:0];
    assign o_tex.red          = r_texel.r;
    assign o_tex.green        = r_texel.g;
    assign o_tex.blue         = r_texel.b;
    assign o_tex.alpha        = r_texel.a;
    assign o_tex.last_texel   = (r_out_cnt == tdec_pkg::CNT_LAST);

endmodule

>>> hdl/compressed_4x4_texture_block_decode.sv
// Top level of the 4x4 compressed texture block decoder.
// Path: palette register, emitter block register, then the texel output register.
// The emitter sends one texel per cycle while the texel sink holds ready; a block is sixteen texels.
// A block word is taken while the previous block is still being sent out.
// Reset (synchronous, active low) empties all stages and sets the output format to 8-bit.
`timescale 1ns / 1ps

module compressed_4x4_texture_block_decode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    tdec_blk_if.sink    i_blk,
    tdec_tex_if.source  o_tex
);

    logic             r_output_format;
    logic             pal_valid;
    logic             pal_ready;
    tdec_pkg::t_block pal;

    // Output format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_format <= tdec_pkg::FMT_8BIT;
        end else if (i_cfg_we) begin
            r_output_format <= i_cfg_wdata;
        end
    end

    tdec_palette_stage u_palette (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_output_format (r_output_format),
        .i_blk           (i_blk),
        .o_pal_valid     (pal_valid),
        .i_pal_ready     (pal_ready),
        .o_pal           (pal)
    );

    tdec_texel_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pal_valid (pal_valid),
        .o_pal_ready (pal_ready),
        .i_pal       (pal),
        .o_tex       (o_tex)
    );

endmodule

>>> tb/tdec_texel_checker.sv
// Watches the block and texel channels, predicts every texel word and compares it.
`timescale 1ns / 1ps

module tdec_texel_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    tdec_blk_if  i_blk,
    tdec_tex_if  i_tex,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } t_texel_word;

    logic        fmt_6bit;
    t_texel_word expected_texels[$];
    int          fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Print one line per mismatch (up to a cap) and count them all
    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_cnt < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_cnt++;
    endtask

    // 5-bit channel to 8 bits: shift up and refill the low bits from the top
    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, 3'b000} | {5'b00000, c[4:2]};
    endfunction

    function automatic tdec_pkg::t_texel unpack_color(input logic [14:0] c, input logic [7:0] a);
        tdec_pkg::t_texel t;
        t.r = expand5(c[4:0]);
        t.g = expand5(c[9:5]);
        t.b = expand5(c[14:10]);
        t.a = a;
        return t;
    endfunction

    // Weight 5 on x and 3 on y, divide by 64 to land on a 5-bit channel
    function automatic logic [4:0] mix53(input logic [7:0] x, input logic [7:0] y);
        int s;
        s = int'(x) * 5 + int'(y) * 3;
        return 5'(s >> 6);
    endfunction

    function automatic tdec_pkg::t_texel mix_color(input tdec_pkg::t_texel p,
                                                   input tdec_pkg::t_texel q);
        return unpack_color({mix53(p.b, q.b), mix53(p.g, q.g), mix53(p.r, q.r)}, 8'd255);
    endfunction

    function automatic logic [7:0] half_sum(input logic [7:0] x, input logic [7:0] y);
        return 8'((int'(x) + int'(y)) >> 1);
    endfunction

    // Build the four-color palette of the accepted block and queue its sixteen texels
    task automatic predict_texels();
        tdec_pkg::t_texel pal [4];
        tdec_pkg::t_texel pick;
        t_texel_word      w;
        logic [1:0]       sel;
        int               k;
        pal[0] = unpack_color(i_blk.color_zero, 8'd255);
        pal[1] = unpack_color(i_blk.color_one, 8'd255);
        case (tdec_pkg::t_blend_mode'(i_blk.blend_mode))
            tdec_pkg::MODE_TRANSP: begin
                pal[2] = unpack_color(i_blk.color_two, 8'd255);
                pal[3] = unpack_color(tdec_pkg::WHITE_15, 8'd0);
            end
            tdec_pkg::MODE_AVG: begin
                pal[2].r = half_sum(pal[0].r, pal[1].r);
                pal[2].g = half_sum(pal[0].g, pal[1].g);
                pal[2].b = half_sum(pal[0].b, pal[1].b);
                pal[2].a = 8'd255;
                pal[3] = unpack_color(tdec_pkg::WHITE_15, 8'd0);
            end
            tdec_pkg::MODE_FOUR: begin
                pal[2] = unpack_color(i_blk.color_two, 8'd255);
                pal[3] = unpack_color(i_blk.color_three, 8'd255);
            end
            default: begin
                pal[2] = mix_color(pal[0], pal[1]);
                pal[3] = mix_color(pal[1], pal[0]);
            end
        endcase

        // Drop to 6-bit channels and 5-bit alpha
        if (fmt_6bit == tdec_pkg::FMT_6BIT) begin
            for (k = 0; k < 4; k++) begin
                pal[k].r = pal[k].r >> 2;
                pal[k].g = pal[k].g >> 2;
                pal[k].b = pal[k].b >> 2;
                pal[k].a = pal[k].a >> 3;
            end
        end

        for (k = 0; k < 16; k++) begin
            sel  = i_blk.texel_indices[2*k +: 2];
            pick = pal[sel];
            if (i_blk.past_slot_end)
                pick = '0;
            w.row  = 2'(k >> 2);
            w.col  = 2'(k & 3);
            w.r    = pick.r;
            w.g    = pick.g;
            w.b    = pick.b;
            w.a    = pick.a;
            w.last = (k == 15);
            expected_texels.push_back(w);
        end
    endtask

    // Compare an accepted texel word with the oldest prediction
    task automatic check_texel();
        t_texel_word want;
        if (expected_texels.size() == 0) begin
            report_mismatch("texel word with nothing expected (row*4+column)",
                            int'({i_tex.texel_row, i_tex.texel_column}), -1);
            return;
        end
        want = expected_texels.pop_front();
        if (i_tex.texel_row !== want.row)
            report_mismatch("texel_row", int'(i_tex.texel_row), int'(want.row));
        if (i_tex.texel_column !== want.col)
            report_mismatch("texel_column", int'(i_tex.texel_column), int'(want.col));
        if (i_tex.red !== want.r)
            report_mismatch("red", int'(i_tex.red), int'(want.r));
        if (i_tex.green !== want.g)
            report_mismatch("green", int'(i_tex.green), int'(want.g));
        if (i_tex.blue !== want.b)
            report_mismatch("blue", int'(i_tex.blue), int'(want.b));
        if (i_tex.alpha !== want.a)
            report_mismatch("alpha", int'(i_tex.alpha), int'(want.a));
        if (i_tex.last_texel !== want.last)
            report_mismatch("last_texel", int'(i_tex.last_texel), int'(want.last));
    endtask

    // Track the format register, predict on each block word, check each texel word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_6bit = tdec_pkg::FMT_8BIT;
            expected_texels.delete();
        end else begin
            if (i_cfg_we)
                fmt_6bit = i_cfg_wdata;
            if (i_blk.valid && i_blk.ready)
                predict_texels();
            if (i_tex.valid && i_tex.ready)
                check_texel();
        end
        o_pending <= expected_texels.size();
    end

endmodule

>>> tb/compressed_4x4_texture_block_decode_test.sv
// Top of the texture block decoder test: clock, reset, block stimulus, texel sink and verdict.
`timescale 1ns / 1ps

module compressed_4x4_texture_block_decode_test;

    localparam int RANDOM_BLOCKS = 480;
    localparam int RANDOM_PHASES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic [31:0]           indices;
        tdec_pkg::t_blend_mode mode;
        logic [14:0]           c0;
        logic [14:0]           c1;
        logic [14:0]           c2;
        logic [14:0]           c3;
        logic                  dead;
    } t_block_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   fail_count;
    int   texels_pending;
    bit   src_gaps_on;
    bit   sink_gaps_on;
    bit   hold_request;

    tdec_blk_if blk ();
    tdec_tex_if tex ();

    compressed_4x4_texture_block_decode u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_blk       (blk),
        .o_tex       (tex)
    );

    tdec_texel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_blk        (blk),
        .i_tex        (tex),
        .o_fail_count (fail_count),
        .o_pending    (texels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Texel sink: random stall bursts, plus one long hold-off on request
    initial begin : texel_sink
        int hold;
        tex.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                tex.ready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++)
                    @(posedge i_clk);
            end else if (sink_gaps_on && $urandom_range(0, 9) == 0) begin
                tex.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                tex.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_block_word make_block(input logic [31:0] indices,
                                               input tdec_pkg::t_blend_mode mode,
                                               input logic [14:0] c0, input logic [14:0] c1,
                                               input logic [14:0] c2, input logic [14:0] c3,
                                               input logic dead);
        t_block_word w;
        w.indices = indices;
        w.mode    = mode;
        w.c0      = c0;
        w.c1      = c1;
        w.c2      = c2;
        w.c3      = c3;
        w.dead    = dead;
        return w;
    endfunction

    // Lean toward black and white now and then, otherwise any color
    function automatic logic [14:0] pick_color();
        case ($urandom_range(0, 7))
            0:       return 15'h0000;
            1:       return 15'h7FFF;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic t_block_word random_block();
        return make_block($urandom, tdec_pkg::t_blend_mode'($urandom_range(0, 3)), pick_color(),
                          pick_color(), pick_color(), pick_color(), $urandom_range(0, 7) == 0);
    endfunction

    // Offer one block word, with an optional gap first, and hold it until taken
    task automatic send_block(input t_block_word w);
        if (src_gaps_on && $urandom_range(0, 7) == 0) begin
            blk.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        blk.valid         <= 1'b1;
        blk.texel_indices <= w.indices;
        blk.blend_mode    <= w.mode;
        blk.color_zero    <= w.c0;
        blk.color_one     <= w.c1;
        blk.color_two     <= w.c2;
        blk.color_three   <= w.c3;
        blk.past_slot_end <= w.dead;
        do @(posedge i_clk); while (!blk.ready);
    endtask

    // Drop valid and wait until every predicted texel has come out
    task automatic wait_idle();
        blk.valid <= 1'b0;
        do @(posedge i_clk); while (texels_pending != 0);
    endtask

    task automatic set_format(input logic fmt);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Extremes of the colors and indices, every mode, the average with odd sums,
    // both blend orders and overrun blocks
    task automatic run_directed();
        send_block(make_block(32'h0000_0000, tdec_pkg::MODE_TRANSP, 15'h0000, 15'h7FFF,
                              15'h1234, 15'h4321, 1'b0));
        send_block(make_block(32'hFFFF_FFFF, tdec_pkg::MODE_TRANSP, 15'h7FFF, 15'h0000,
                              15'h7FFF, 15'h0000, 1'b0));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_TRANSP, 15'h7C00, 15'h03E0,
                              15'h001F, 15'h7FFF, 1'b0));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_AVG, 15'h0421, 15'h7FFF,
                              15'h5555, 15'h2AAA, 1'b0));
        send_block(make_block(32'h1B1B_1B1B, tdec_pkg::MODE_AVG, 15'h7FFF, 15'h7FFF,
                              15'h0000, 15'h7FFF, 1'b0));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_FOUR, 15'h0000, 15'h7FFF,
                              15'h7FFF, 15'h0000, 1'b0));
        send_block(make_block(32'h1B1B_1B1B, tdec_pkg::MODE_FOUR, 15'h1234, 15'h6543,
                              15'h5294, 15'h294A, 1'b0));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_BLEND, 15'h0000, 15'h7FFF,
                              15'h7FFF, 15'h7FFF, 1'b0));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_BLEND, 15'h7FFF, 15'h0000,
                              15'h0000, 15'h0000, 1'b0));
        send_block(make_block(32'h4E4E_4E4E, tdec_pkg::MODE_BLEND, 15'h0C63, 15'h6739,
                              15'h1111, 15'h2222, 1'b0));
        send_block(make_block(32'hFFFF_FFFF, tdec_pkg::MODE_TRANSP, 15'h7FFF, 15'h7FFF,
                              15'h7FFF, 15'h7FFF, 1'b1));
        send_block(make_block(32'hE4E4_E4E4, tdec_pkg::MODE_BLEND, 15'h7FFF, 15'h0421,
                              15'h7FFF, 15'h7FFF, 1'b1));
    endtask

    initial begin : stimulus
        int phase;
        int n;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= tdec_pkg::FMT_8BIT;
        blk.valid         <= 1'b0;
        blk.texel_indices <= '0;
        blk.blend_mode    <= tdec_pkg::MODE_TRANSP;
        blk.color_zero    <= '0;
        blk.color_one     <= '0;
        blk.color_two     <= '0;
        blk.color_three   <= '0;
        blk.past_slot_end <= 1'b0;
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        hold_request = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks in both formats
        set_format(tdec_pkg::FMT_8BIT);
        run_directed();
        wait_idle();
        set_format(tdec_pkg::FMT_6BIT);
        run_directed();

        // Random blocks, switching format between phases; last phase runs without gaps
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            set_format(phase[0] ? tdec_pkg::FMT_6BIT : tdec_pkg::FMT_8BIT);
            if (phase == RANDOM_PHASES - 1) begin
                src_gaps_on  = 1'b0;
                sink_gaps_on = 1'b0;
            end
            for (n = 0; n < RANDOM_BLOCKS / RANDOM_PHASES; n++) begin
                if (phase == 1 && n == 8)
                    hold_request = 1'b1;
                send_block(random_block());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
